FILE: rtl/hpu_pkg.sv
// ----------------------------------------------------------------------------
// hpu_pkg
// Shared types and constants of the Hebbian principal-component learner.
// ----------------------------------------------------------------------------
package hpu_pkg;

	localparam int MAX_COMPONENTS = 16;
	localparam int MAX_LENGTH     = 64;
	localparam int VALUE_BITS     = 16;
	localparam int ROW_BITS       = 4;
	localparam int COL_BITS       = 6;
	localparam int MUL_BITS       = 33;

	// Item operation codes.
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_LEARN   = 2'd2,
		OP_PROJECT = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_COMPONENTS = 2'd0,
		REG_LENGTH     = 2'd1,
		REG_RATE       = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	// Result kinds.
	localparam logic KIND_WEIGHT    = 1'b0;
	localparam logic KIND_COMPONENT = 1'b1;

	// Effective configuration as seen by the sequencer.
	typedef struct packed {
		logic [ROW_BITS-1:0] comp_m1;
		logic [COL_BITS-1:0] len_m1;
		logic [15:0]         rate;
	} cfg_t;

endpackage

FILE: rtl/hebbian_pca_update.sv
// ----------------------------------------------------------------------------
// hebbian_pca_update
// Principal-component learner by Sanger's rule around one shared multiplier.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; results appear on
// the result ports for one cycle each, marked by strobe, and cannot be held
// off. A weight write or a sample element without last leaves the block
// idle; a weight read passes through a read state. The last element of a
// sample starts the projection, each multiply-accumulate passing address,
// multiply and accumulate states on the shared multiplier, and for a learn
// item then the row updates. Weight and sample stores are unset after reset.
module hebbian_pca_update import hpu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [3:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] value,
	input  logic               last,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	output logic               strobe,
	output logic               kind,
	output logic [3:0]         index,
	output logic signed [31:0] result_value,
	output logic               final_res
);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_RD    = 15'b000000000000010,
		S_PADDR = 15'b000000000000100,
		S_PMUL  = 15'b000000000001000,
		S_PACC  = 15'b000000000010000,
		S_POUT  = 15'b000000000100000,
		S_LADDR = 15'b000000001000000,
		S_LMUL  = 15'b000000010000000,
		S_LACC  = 15'b000000100000000,
		S_LERR  = 15'b000001000000000,
		S_LPM   = 15'b000010000000000,
		S_LPR   = 15'b000100000000000,
		S_LD1   = 15'b001000000000000,
		S_LD2   = 15'b010000000000000,
		S_LD3   = 15'b100000000000000
	} state_t;

	cfg_t   cfg;
	state_t state_q;
	logic   accept;
	logic   learn_q;
	logic   lphase_q;
	logic [ROW_BITS-1:0] u_q;
	logic [ROW_BITS-1:0] q_q;
	logic [COL_BITS-1:0] v_q;
	logic [ROW_BITS-1:0] row_q;

	// Stores.
	logic signed [VALUE_BITS-1:0] wmem [MAX_COMPONENTS*MAX_LENGTH];
	logic signed [VALUE_BITS-1:0] smem [MAX_LENGTH];
	logic signed [31:0]           ymem [MAX_COMPONENTS];
	logic signed [VALUE_BITS-1:0] wdata_q;
	logic signed [VALUE_BITS-1:0] sdata_q;
	logic signed [31:0]           ydata_q;
	logic [ROW_BITS+COL_BITS-1:0] wrd_addr;

	// Datapath registers.
	logic signed [47:0] acc_q;
	logic signed [15:0] wold_q;
	logic signed [31:0] yu_q;
	logic signed [31:0] e_q;
	logic signed [47:0] p_q;
	logic signed [40:0] lo_q;

	// Multiplier and arithmetic.
	logic signed [MUL_BITS-1:0]   mul_a;
	logic signed [MUL_BITS-1:0]   mul_b;
	logic signed [2*MUL_BITS-1:0] prod;
	logic signed [48:0] acc_sum;
	logic signed [47:0] acc_sat;
	logic signed [48:0] y_pre;
	logic signed [36:0] y_sh;
	logic signed [31:0] y_sat;
	logic signed [48:0] e_pre;
	logic signed [36:0] e_sh;
	logic signed [31:0] e_sat;
	logic signed [65:0] p_pre;
	logic signed [53:0] p_sh;
	logic signed [47:0] p_sat;
	logic signed [65:0] d_pre;
	logic signed [49:0] d_sh;
	logic signed [50:0] w_sum;
	logic signed [15:0] w_sat;

	hpu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	hpu_mult u_mult (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Weight read address: the item's own in idle, else the walking counters.
	assign wrd_addr = (state_q == S_IDLE) ? {row, col} :
		(lphase_q ? {q_q, v_q} : {u_q, v_q});

	// Weight store.
	always_ff @(posedge clk) begin
		if (accept && (op_t'(op) == OP_WRITE)) begin
			wmem[{row, col}] <= value;
		end else if (state_q == S_LD3) begin
			wmem[{u_q, v_q}] <= w_sat;
		end
		wdata_q <= wmem[wrd_addr];
	end

	// Sample and component output stores.
	always_ff @(posedge clk) begin
		if (accept && op[1]) begin
			smem[col] <= value;
		end
		sdata_q <= smem[v_q];
		if (state_q == S_POUT) begin
			ymem[u_q] <= y_sat;
		end
		ydata_q <= ymem[q_q];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_PMUL: begin
				mul_a = MUL_BITS'(wdata_q);
				mul_b = MUL_BITS'(sdata_q);
			end
			S_LMUL: begin
				mul_a = MUL_BITS'(ydata_q);
				mul_b = MUL_BITS'(wdata_q);
			end
			S_LPM: begin
				mul_a = MUL_BITS'(yu_q);
				mul_b = MUL_BITS'(e_q);
			end
			S_LD1: begin
				mul_a = $signed({9'b0, p_q[23:0]});
				mul_b = $signed({17'b0, cfg.rate});
			end
			S_LD2: begin
				mul_a = MUL_BITS'($signed(p_q[47:24]));
				mul_b = $signed({17'b0, cfg.rate});
			end
			default: ;
		endcase
	end

	// Rounding and saturation; every rounding adds half then floors.
	always_comb begin
		acc_sum = 49'(acc_q) + 49'($signed(prod[47:0]));
		if (acc_sum[48] != acc_sum[47]) begin
			acc_sat = acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_sat = acc_sum[47:0];
		end

		y_pre = 49'(acc_q) + 49'sd2048;
		y_sh  = 37'(y_pre >>> 12);
		if (y_sh > 37'sh7fffffff) y_sat = 32'sh7fffffff;
		else if (y_sh < -37'sh80000000) y_sat = 32'sh80000000;
		else y_sat = y_sh[31:0];

		e_pre = $signed({{21{sdata_q[15]}}, sdata_q, 12'b0}) - 49'(acc_q) + 49'sd2048;
		e_sh  = 37'(e_pre >>> 12);
		if (e_sh > 37'sh7fffffff) e_sat = 32'sh7fffffff;
		else if (e_sh < -37'sh80000000) e_sat = 32'sh80000000;
		else e_sat = e_sh[31:0];

		p_pre = prod + 66'sd2048;
		p_sh  = 54'(p_pre >>> 12);
		if (p_sh > 54'sh7fffffffffff) p_sat = {1'b0, {47{1'b1}}};
		else if (p_sh < -54'sh800000000000) p_sat = {1'b1, 47'b0};
		else p_sat = p_sh[47:0];

		d_pre = (prod <<< 24) + 66'(lo_q) + 66'sd32768;
		d_sh  = 50'(d_pre >>> 16);
		w_sum = 51'(d_sh) + 51'(wold_q);
		if (w_sum > 51'sd32767) w_sat = 16'sh7fff;
		else if (w_sum < -51'sd32768) w_sat = 16'sh8000;
		else w_sat = w_sum[15:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			learn_q  <= 1'b0;
			lphase_q <= 1'b0;
			u_q      <= '0;
			q_q      <= '0;
			v_q      <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op_t'(op) == OP_READ) begin
							state_q <= S_RD;
						end else if (op[1] && last) begin
							learn_q  <= (op_t'(op) == OP_LEARN);
							lphase_q <= 1'b0;
							u_q      <= '0;
							v_q      <= '0;
							q_q      <= '0;
							state_q  <= S_PADDR;
						end
					end
				end
				S_RD: begin
					strobe  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PADDR: state_q <= S_PMUL;
				S_PMUL:  state_q <= S_PACC;
				S_PACC: begin
					if (v_q == cfg.len_m1) begin
						state_q <= S_POUT;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_PADDR;
					end
				end
				S_POUT: begin
					strobe <= 1'b1;
					v_q    <= '0;
					if (u_q == cfg.comp_m1) begin
						if (learn_q) begin
							lphase_q <= 1'b1;
							q_q      <= '0;
							state_q  <= S_LADDR;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						u_q     <= u_q + 1'b1;
						state_q <= S_PADDR;
					end
				end
				S_LADDR: state_q <= S_LMUL;
				S_LMUL:  state_q <= S_LACC;
				S_LACC: begin
					if (q_q == u_q) begin
						state_q <= S_LERR;
					end else begin
						q_q     <= q_q + 1'b1;
						state_q <= S_LADDR;
					end
				end
				S_LERR: state_q <= S_LPM;
				S_LPM:  state_q <= S_LPR;
				S_LPR:  state_q <= S_LD1;
				S_LD1:  state_q <= S_LD2;
				S_LD2:  state_q <= S_LD3;
				S_LD3: begin
					q_q <= '0;
					if (v_q == cfg.len_m1) begin
						v_q <= '0;
						if (u_q == '0) begin
							lphase_q <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							u_q     <= u_q - 1'b1;
							state_q <= S_LADDR;
						end
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_LADDR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row;
		end
		case (state_q)
			S_IDLE: acc_q <= '0;
			S_RD: begin
				kind         <= KIND_WEIGHT;
				index        <= row_q;
				result_value <= 32'(wdata_q);
				final_res    <= 1'b1;
			end
			S_PACC: acc_q <= acc_sat;
			S_POUT: begin
				kind         <= KIND_COMPONENT;
				index        <= u_q;
				result_value <= y_sat;
				final_res    <= (u_q == cfg.comp_m1);
				acc_q        <= '0;
			end
			S_LMUL: begin
				if (q_q == u_q) begin
					wold_q <= wdata_q;
					yu_q   <= ydata_q;
				end
			end
			S_LACC: acc_q <= acc_sat;
			S_LERR: e_q   <= e_sat;
			S_LPR:  p_q   <= p_sat;
			S_LD2:  lo_q  <= $signed(prod[40:0]);
			S_LD3:  acc_q <= '0;
			default: ;
		endcase
	end

endmodule

FILE: rtl/hpu_cfg.sv
// ----------------------------------------------------------------------------
// hpu_cfg
// Configuration registers and the limited component count and length.
// ----------------------------------------------------------------------------
module hpu_cfg import hpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	logic [4:0]  comp_q;
	logic [6:0]  len_q;
	logic [15:0] rate_q;
	logic [6:0]  len_c;
	logic [6:0]  comp_a;
	logic [6:0]  comp_b;
	logic [6:0]  comp_c;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= 5'd1;
			len_q  <= 7'd1;
			rate_q <= 16'd655;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_COMPONENTS: comp_q <= wr_data[4:0];
				REG_LENGTH:     len_q  <= wr_data[6:0];
				REG_RATE:       rate_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Limit the length to one..maximum and the count to one..maximum..length.
	always_comb begin
		len_c  = (len_q == 7'd0) ? 7'd1 :
			((len_q > 7'(MAX_LENGTH)) ? 7'(MAX_LENGTH) : len_q);
		comp_a = (comp_q == 5'd0) ? 7'd1 : {2'b00, comp_q};
		comp_b = (comp_a > 7'(MAX_COMPONENTS)) ? 7'(MAX_COMPONENTS) : comp_a;
		comp_c = (comp_b > len_c) ? len_c : comp_b;
		cfg.len_m1  = COL_BITS'(len_c - 7'd1);
		cfg.comp_m1 = ROW_BITS'(comp_c - 7'd1);
		cfg.rate    = rate_q;
	end

endmodule

FILE: rtl/hpu_mult.sv
// ----------------------------------------------------------------------------
// hpu_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hpu_mult import hpu_pkg::*; (
	input  logic                         clk,
	input  logic signed [MUL_BITS-1:0]   a,
	input  logic signed [MUL_BITS-1:0]   b,
	output logic signed [2*MUL_BITS-1:0] p_q
);

	// One product per cycle, ready in the next.
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule
